// File: design/bounded_set_membership_table_macros.svh
// ----------------------------------------------------------------------------
// Bounded set membership table assertion macros
// Concurrent assertion wrappers shared by the controller and datapath modules.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_SET_MEMBERSHIP_TABLE_MACROS_SVH
`define BOUNDED_SET_MEMBERSHIP_TABLE_MACROS_SVH
`ifndef SYNTHESIS
`define BSMT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BSMT_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BSMT_ASSERT(lbl, prop, msg)
`define BSMT_ASSERT_RST(lbl, prop, msg)
`endif
`endif

// File: design/bsmt_pkg.sv
// ----------------------------------------------------------------------------
// Bounded set membership table package
// Sizes, operation codes, controller states and shared types.
// ----------------------------------------------------------------------------
`default_nettype none

package bsmt_pkg;

  localparam int CAPACITY  = 16;
  localparam int ELEM_W    = 32;
  localparam int IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int OUT_CNT_W = 5;
  localparam int GRP_SIZE  = 4;
  localparam int NUM_GRP   = (CAPACITY + GRP_SIZE - 1) / GRP_SIZE;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_QUERY  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_MINA,
    ST_MINB
  } state_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic min_a;
    logic min_b;
  } ctl_cmd_t;

  typedef struct packed {
    logic              vld;
    logic [ELEM_W-1:0] val;
  } min_ent_t;

  function automatic min_ent_t min_pick(input min_ent_t a, input min_ent_t b);
    min_ent_t r;
    if (a.vld && (!b.vld || (a.val <= b.val))) begin
      r = a;
    end else begin
      r = b;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: design/bsmt_ctrl.sv
// ----------------------------------------------------------------------------
// Bounded set membership table controller
// Sequences one transaction through update and the two minimum tree stages.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bounded_set_membership_table_macros.svh"

module bsmt_ctrl
  import bsmt_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output logic          busy,
  output logic          out_valid,
  output ctl_cmd_t      cmd
);

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    cmd           = '0;
    busy          = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = ST_MINA;
      end
      ST_MINA: begin
        cmd.min_a = 1'b1;
        state_nxt = ST_MINB;
      end
      ST_MINB: begin
        cmd.min_b     = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

  `BSMT_ASSERT(a_accept_busy, start && !busy |=> busy, "busy not raised after accept")
  `BSMT_ASSERT(a_strobe_pulse, out_valid |=> !out_valid, "result strobe longer than one cycle")
  `BSMT_ASSERT(a_cmd_onehot, $onehot0(cmd), "more than one datapath command active")
  `BSMT_ASSERT_RST(a_reset_idle, !rst_n |=> !busy && !out_valid, "not idle after reset")

endmodule

`default_nettype wire

// File: design/bsmt_dpath.sv
// ----------------------------------------------------------------------------
// Bounded set membership table datapath
// Slot table with valid marks, parallel compare, count and minimum tree.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bounded_set_membership_table_macros.svh"

module bsmt_dpath
  import bsmt_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire ctl_cmd_t             cmd,
  input  wire logic [1:0]           in_kind,
  input  wire logic [ELEM_W-1:0]    in_value,
  output logic                      out_was_member,
  output logic                      out_status,
  output logic [OUT_CNT_W-1:0]      out_member_count,
  output logic                      out_is_empty,
  output logic [ELEM_W-1:0]         out_min_value
);

  logic [1:0]           kind_r;
  logic [ELEM_W-1:0]    value_r;
  logic [ELEM_W-1:0]    slot_value_r [CAPACITY];
  logic [CAPACITY-1:0]  slot_valid_r;
  logic [CAPACITY-1:0]  slot_valid_nxt;
  logic [CNT_W-1:0]     count_r;
  logic [CNT_W-1:0]     count_nxt;
  logic                 was_member_r;
  logic                 status_r;
  logic                 status_nxt;
  min_ent_t             grp_min_r [NUM_GRP];
  min_ent_t             grp_min_nxt [NUM_GRP];
  min_ent_t             all_min;
  logic [ELEM_W-1:0]    min_value_r;
  logic [OUT_CNT_W-1:0] member_count_r;
  logic                 is_empty_r;
  logic [CAPACITY-1:0]  hit_vec;
  logic                 hit;
  logic                 full;
  logic [IDX_W-1:0]     hit_idx;
  logic [IDX_W-1:0]     free_idx;
  logic                 slot_wr;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r  <= in_kind;
      value_r <= in_value;
    end
  end

  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      hit_vec[i] = slot_valid_r[i] && (slot_value_r[i] == value_r);
      if (hit_vec[i]) begin
        hit_idx = IDX_W'(i);
      end
      if (!slot_valid_r[i]) begin
        free_idx = IDX_W'(i);
      end
    end
    hit  = |hit_vec;
    full = &slot_valid_r;
  end

  always_comb begin
    slot_valid_nxt = slot_valid_r;
    count_nxt      = count_r;
    status_nxt     = 1'b0;
    slot_wr        = 1'b0;
    unique case (kind_r)
      KIND_INSERT: begin
        if (!hit) begin
          if (full) begin
            status_nxt = 1'b1;
          end else begin
            slot_wr                  = 1'b1;
            slot_valid_nxt[free_idx] = 1'b1;
            count_nxt                = count_r + CNT_W'(1);
          end
        end
      end
      KIND_REMOVE: begin
        if (hit) begin
          slot_valid_nxt[hit_idx] = 1'b0;
          count_nxt               = count_r - CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && slot_wr) begin
      slot_value_r[free_idx] <= value_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_valid_r <= '0;
      count_r      <= '0;
    end else if (cmd.exec) begin
      slot_valid_r <= slot_valid_nxt;
      count_r      <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      was_member_r <= hit;
      status_r     <= status_nxt;
    end
  end

  always_comb begin
    min_ent_t ent;
    for (int g = 0; g < NUM_GRP; g++) begin
      grp_min_nxt[g] = '0;
      for (int j = 0; j < GRP_SIZE; j++) begin
        if (g * GRP_SIZE + j < CAPACITY) begin
          ent.vld        = slot_valid_r[g * GRP_SIZE + j];
          ent.val        = slot_value_r[g * GRP_SIZE + j];
          grp_min_nxt[g] = min_pick(grp_min_nxt[g], ent);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.min_a) begin
      grp_min_r <= grp_min_nxt;
    end
  end

  always_comb begin
    all_min = '0;
    for (int g = 0; g < NUM_GRP; g++) begin
      all_min = min_pick(all_min, grp_min_r[g]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.min_b) begin
      min_value_r    <= all_min.vld ? all_min.val : '0;
      member_count_r <= OUT_CNT_W'(count_r);
      is_empty_r     <= (count_r == '0);
    end
  end

  assign out_was_member   = was_member_r;
  assign out_status       = status_r;
  assign out_member_count = member_count_r;
  assign out_is_empty     = is_empty_r;
  assign out_min_value    = min_value_r;

  `BSMT_ASSERT(a_count_marks, $countones(slot_valid_r) == count_r, "count disagrees with valid marks")
  `BSMT_ASSERT(a_count_bound, count_r <= CNT_W'(CAPACITY), "count above capacity")
  `BSMT_ASSERT(a_refuse_full, cmd.exec && status_nxt |=> count_r == CNT_W'(CAPACITY), "refused insert while not full")

endmodule

`default_nettype wire

// File: design/bounded_set_membership_table.sv
// ----------------------------------------------------------------------------
// Bounded set membership table
// Set of distinct values in a small slot table: insert, remove and query,
// each reporting prior membership, count, empty flag and minimum member.
// ----------------------------------------------------------------------------
// Channel   Ports                                Handshake
// input     in_kind, in_value                    start high while busy low
// result    out_was_member, out_status,          out_valid, one cycle,
//           out_member_count, out_is_empty,      no back-pressure
//           out_min_value
//
// A transaction is loaded into registers on acceptance, then passes through
// the parallel compare and slot update and the two registered minimum tree
// stages over the slots, after which the result is presented.
// The result strobe rises in the cycle after the last tree stage, and busy
// falls in the same cycle, so a new transaction may start there.
// Synchronous reset clears all valid marks and the count at once.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_set_membership_table
  import bsmt_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [1:0]           in_kind,
  input  wire logic [ELEM_W-1:0]    in_value,
  output logic                      out_valid,
  output logic                      out_was_member,
  output logic                      out_status,
  output logic [OUT_CNT_W-1:0]      out_member_count,
  output logic                      out_is_empty,
  output logic [ELEM_W-1:0]         out_min_value
);

  ctl_cmd_t cmd;

  bsmt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  bsmt_dpath u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_kind          (in_kind),
    .in_value         (in_value),
    .out_was_member   (out_was_member),
    .out_status       (out_status),
    .out_member_count (out_member_count),
    .out_is_empty     (out_is_empty),
    .out_min_value    (out_min_value)
  );

endmodule

`default_nettype wire

// File: test/bounded_set_membership_table_test.sv
// ----------------------------------------------------------------------------
// Bounded set membership table testbench
// Drives insert, remove and query transactions into the set table: first a
// directed run over the empty, full and present-value cases, then random
// traffic over a small value pool so that values hit and the table fills.
// A scoreboard class keeps its own copy of the slot table and checks each
// result field against it.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_set_membership_table_test;
  import bsmt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int POOL_SIZE = 20;

  typedef struct {
    logic                 was_member;
    logic                 status;
    logic [OUT_CNT_W-1:0] member_count;
    logic                 is_empty;
    logic [ELEM_W-1:0]    min_value;
  } set_result_t;

  class membership_checker;
    logic [ELEM_W-1:0] stored[CAPACITY];
    bit                occupied[CAPACITY];
    int unsigned       members;
    set_result_t       expected_results[$];
    int                errors;

    function new();
      members = 0;
      errors = 0;
      foreach (occupied[i]) begin
        occupied[i] = 1'b0;
        stored[i] = '0;
      end
    endfunction

    function int outstanding();
      return expected_results.size();
    endfunction

    function void apply_op(input logic [1:0] kind, input logic [ELEM_W-1:0] value);
      set_result_t r;
      int hit;
      int free;
      bit seen;
      hit = -1;
      free = -1;
      seen = 0;
      r.status = 1'b0;
      r.min_value = '0;
      for (int i = 0; i < CAPACITY; i++) begin
        if (occupied[i] && stored[i] == value && hit < 0) hit = i;
        if (!occupied[i] && free < 0) free = i;
      end
      if (kind == KIND_INSERT) begin
        if (hit < 0) begin
          if (free < 0) begin
            r.status = 1'b1;
          end else begin
            stored[free] = value;
            occupied[free] = 1'b1;
            members++;
          end
        end
      end else if (kind == KIND_REMOVE) begin
        if (hit >= 0) begin
          occupied[hit] = 1'b0;
          members--;
        end
      end
      for (int i = 0; i < CAPACITY; i++) begin
        if (occupied[i] && (!seen || stored[i] < r.min_value)) begin
          r.min_value = stored[i];
          seen = 1;
        end
      end
      r.was_member = (hit >= 0);
      r.member_count = members[OUT_CNT_W-1:0];
      r.is_empty = (members == 0);
      expected_results.push_back(r);
    endfunction

    function void check_field(input string name, input logic [ELEM_W-1:0] exp_v,
                              input logic [ELEM_W-1:0] act_v);
      if (exp_v !== act_v) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(input set_result_t act);
      set_result_t exp_r;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual member %0b count %0d min %0h",
                 $time, act.was_member, act.member_count, act.min_value);
        errors++;
        return;
      end
      exp_r = expected_results.pop_front();
      check_field("was_member", ELEM_W'(exp_r.was_member), ELEM_W'(act.was_member));
      check_field("status", ELEM_W'(exp_r.status), ELEM_W'(act.status));
      check_field("member_count", ELEM_W'(exp_r.member_count), ELEM_W'(act.member_count));
      check_field("is_empty", ELEM_W'(exp_r.is_empty), ELEM_W'(act.is_empty));
      check_field("min_value", exp_r.min_value, act.min_value);
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic [1:0]           in_kind;
  logic [ELEM_W-1:0]    in_value;
  logic                 out_valid;
  logic                 out_was_member;
  logic                 out_status;
  logic [OUT_CNT_W-1:0] out_member_count;
  logic                 out_is_empty;
  logic [ELEM_W-1:0]    out_min_value;

  membership_checker table_check = new();
  int                send_idle_pct;
  int                cycle_count = 0;
  logic [ELEM_W-1:0] value_pool[POOL_SIZE];

  bounded_set_membership_table dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_kind          (in_kind),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_was_member   (out_was_member),
    .out_status       (out_status),
    .out_member_count (out_member_count),
    .out_is_empty     (out_is_empty),
    .out_min_value    (out_min_value)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    set_result_t act;
    if (rst_n && out_valid) begin
      act.was_member = out_was_member;
      act.status = out_status;
      act.member_count = out_member_count;
      act.is_empty = out_is_empty;
      act.min_value = out_min_value;
      table_check.check_result(act);
    end
  end

  task automatic send_op(input logic [1:0] kind, input logic [ELEM_W-1:0] value);
    in_kind <= kind;
    in_value <= value;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    table_check.apply_op(kind, value);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(5, 1)) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (table_check.outstanding() != 0) @(posedge clk);
  endtask

  function automatic logic [ELEM_W-1:0] pool_value();
    case ($urandom_range(3))
      0: return $urandom_range(31);
      1: return ~$urandom_range(31);
      default: return $urandom;
    endcase
  endfunction

  task automatic run_random(input int count);
    int insert_pct;
    int remove_pct;
    int r;
    logic [1:0] kind;
    logic [ELEM_W-1:0] value;
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) begin
        // Replace only part of the pool so older members stay removable.
        repeat (5) value_pool[$urandom_range(POOL_SIZE - 1)] = pool_value();
        case ($urandom_range(2))
          0: insert_pct = 20;
          1: insert_pct = 50;
          default: insert_pct = 80;
        endcase
        remove_pct = (100 - insert_pct) * 2 / 3;
      end
      r = $urandom_range(99);
      if (r < 2) begin
        kind = KIND_UNUSED;
      end else begin
        r = $urandom_range(99);
        if (r < insert_pct) begin
          kind = KIND_INSERT;
        end else if (r < insert_pct + remove_pct) begin
          kind = KIND_REMOVE;
        end else begin
          kind = KIND_QUERY;
        end
      end
      if ($urandom_range(9) == 0) begin
        value = $urandom;
      end else begin
        value = value_pool[$urandom_range(POOL_SIZE - 1)];
      end
      send_op(kind, value);
    end
  endtask

  task automatic run_directed();
    send_op(KIND_QUERY, 32'h0);
    send_op(KIND_INSERT, 32'hFFFF_FFFF);
    send_op(KIND_INSERT, 32'h0);
    send_op(KIND_INSERT, 32'h0);
    send_op(KIND_QUERY, 32'h0);
    send_op(KIND_QUERY, 32'h5);
    send_op(KIND_UNUSED, 32'h0);
    send_op(KIND_REMOVE, 32'h5);
    for (int j = 0; j < CAPACITY - 2; j++) begin
      send_op(KIND_INSERT, 32'h1 << (2 * j + 2));
    end
    send_op(KIND_INSERT, 32'h1234_5678);
    send_op(KIND_INSERT, 32'hFFFF_FFFF);
    send_op(KIND_REMOVE, 32'h0);
    send_op(KIND_INSERT, 32'h1);
  endtask

  initial begin
    rst_n <= 1'b0;
    start <= 1'b0;
    in_kind <= KIND_QUERY;
    in_value <= '0;
    send_idle_pct = 20;
    foreach (value_pool[i]) value_pool[i] = pool_value();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();
    run_random(580);
    drain();
    send_idle_pct = 60;
    run_random(580);
    drain();
    send_idle_pct = 0;
    run_random(590);
    drain();
    repeat (10) @(posedge clk);

    if (table_check.errors == 0 && table_check.outstanding() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
